// ===== rtl/core/cplf_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cplf_pkg
// Shared types, constants and the arctangent table of the phase line fit.
// ----------------------------------------------------------------------------
package cplf_pkg;

    localparam int MAX_SAMPLES_DEF = 256;
    localparam int PHASE_BITS_DEF  = 16;

    localparam int PROD_W       = 33;   // ref * conj(echo), one component
    localparam int TIME_W       = 32;
    localparam int CORDIC_STEPS = 28;
    localparam int CORDIC_W     = 45;   // normalized vector plus CORDIC gain
    localparam int NORM_SHIFT   = 40;   // normalize until a component reaches 2^40
    localparam int STEP_W       = 5;

    typedef struct packed {
        logic                      fit;     // item enters the fit
        logic signed [PROD_W-1:0]  p_re;
        logic signed [PROD_W-1:0]  p_im;
        logic                      last;
        logic                      cap_ok;
        logic [TIME_W-1:0]         tdiff;
    } t_item;

    // atan(2^-k) in units of 2^32 per turn
    function automatic logic [31:0] cplf_angle(input logic [STEP_W-1:0] k);
        logic [31:0] a;
        case (k)
            5'd0:  a = 32'd536870912;
            5'd1:  a = 32'd316933406;
            5'd2:  a = 32'd167458907;
            5'd3:  a = 32'd85004756;
            5'd4:  a = 32'd42667331;
            5'd5:  a = 32'd21354465;
            5'd6:  a = 32'd10679838;
            5'd7:  a = 32'd5340245;
            5'd8:  a = 32'd2670163;
            5'd9:  a = 32'd1335087;
            5'd10: a = 32'd667544;
            5'd11: a = 32'd333772;
            5'd12: a = 32'd166886;
            5'd13: a = 32'd83443;
            5'd14: a = 32'd41722;
            5'd15: a = 32'd20861;
            5'd16: a = 32'd10430;
            5'd17: a = 32'd5215;
            5'd18: a = 32'd2608;
            5'd19: a = 32'd1304;
            5'd20: a = 32'd652;
            5'd21: a = 32'd326;
            5'd22: a = 32'd163;
            5'd23: a = 32'd81;
            5'd24: a = 32'd41;
            5'd25: a = 32'd20;
            5'd26: a = 32'd10;
            5'd27: a = 32'd5;
            default: a = 32'd0;
        endcase
        return a;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/core/cplf_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cplf_front
// Accepts sample pairs, forms ref * conj(echo), tags the sample index and
// classifies each transaction (enters fit, last) for the queue.
// ----------------------------------------------------------------------------
module cplf_front #(
    parameter int MAX_SAMPLES = cplf_pkg::MAX_SAMPLES_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_valid,
    output logic                                   o_stall,
    input  wire logic signed [15:0]                i_ref_i,
    input  wire logic signed [15:0]                i_ref_q,
    input  wire logic signed [15:0]                i_echo_i,
    input  wire logic signed [15:0]                i_echo_q,
    input  wire logic                              i_last,
    input  wire logic                              i_captures_valid,
    input  wire logic [cplf_pkg::TIME_W-1:0]       i_ref_time,
    input  wire logic [cplf_pkg::TIME_W-1:0]       i_echo_time,
    output logic                                   o_push,
    output cplf_pkg::t_item                        o_item,
    output logic [$clog2(MAX_SAMPLES)-1:0]         o_x,
    input  wire logic                              i_full
);
    import cplf_pkg::*;

    localparam int XW = $clog2(MAX_SAMPLES);
    localparam int CW = $clog2(MAX_SAMPLES + 1);

    logic          r_v;
    t_item         r_item;
    logic [XW-1:0] r_x;
    logic [CW-1:0] r_idx;
    logic          accept;
    logic          in_range;
    logic signed [31:0] m_ii, m_qq, m_qi, m_iq;

    assign o_stall  = r_v && i_full;
    assign accept   = i_valid && !o_stall;
    assign o_push   = r_v && !i_full;
    assign o_item   = r_item;
    assign o_x      = r_x;
    assign in_range = r_idx < CW'(MAX_SAMPLES);

    assign m_ii = i_ref_i * i_echo_i;
    assign m_qq = i_ref_q * i_echo_q;
    assign m_qi = i_ref_q * i_echo_i;
    assign m_iq = i_ref_i * i_echo_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v   <= 1'b0;
            r_idx <= '0;
        end else begin
            r_v <= accept || (r_v && i_full);
            if (accept) begin
                if (i_last) begin
                    r_idx <= '0;
                end else if (in_range) begin
                    r_idx <= r_idx + CW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item.fit    <= in_range && ((i_echo_i != 16'sd0) || (i_echo_q != 16'sd0));
            r_item.p_re   <= PROD_W'(m_ii) + PROD_W'(m_qq);
            r_item.p_im   <= PROD_W'(m_qi) - PROD_W'(m_iq);
            r_item.last   <= i_last;
            r_item.cap_ok <= i_captures_valid;
            r_item.tdiff  <= i_echo_time - i_ref_time;
            r_x           <= r_idx[XW-1:0];
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/cplf_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cplf_queue
// Two-entry queue between the classifying front and the fit back end.
// ----------------------------------------------------------------------------
module cplf_queue #(
    parameter int W = 8
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_push,
    input  wire logic [W-1:0] i_data,
    output logic              o_full,
    input  wire logic         i_pop,
    output logic              o_valid,
    output logic [W-1:0]      o_data
);
    logic [W-1:0] r_slot [2];
    logic         r_wp, r_rp;
    logic [1:0]   r_cnt;

    assign o_full  = r_cnt == 2'd2;
    assign o_valid = r_cnt != 2'd0;
    assign o_data  = r_slot[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= !r_wp;
            end
            if (i_pop) begin
                r_rp <= !r_rp;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wp] <= i_data;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full) else $error("queue push while full");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid) else $error("queue pop while empty");
    a_count_ptrs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd1) |-> (r_wp != r_rp)) else $error("queue pointers disagree");

endmodule
`default_nettype wire

// ===== rtl/core/cplf_cordic.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cplf_cordic
// Iterative angle unit: normalizes the vector one doubling per cycle, folds
// the left half plane, then runs the vectoring steps one per cycle.
// ----------------------------------------------------------------------------
module cplf_cordic #(
    parameter int PHASE_BITS = cplf_pkg::PHASE_BITS_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_start,
    input  wire logic signed [cplf_pkg::PROD_W-1:0]  i_x,
    input  wire logic signed [cplf_pkg::PROD_W-1:0]  i_y,
    output logic                                     o_done,
    output logic signed [PHASE_BITS-1:0]             o_angle
);
    import cplf_pkg::*;

    localparam logic [1:0] C_IDLE = 2'd0;
    localparam logic [1:0] C_NORM = 2'd1;
    localparam logic [1:0] C_ROT  = 2'd2;
    localparam logic [1:0] C_RND  = 2'd3;

    localparam logic [CORDIC_W-1:0] NORM_LIM = CORDIC_W'(1) << NORM_SHIFT;

    logic [1:0]                 r_state;
    logic signed [CORDIC_W-1:0] r_x, r_y;
    logic [31:0]                r_z;
    logic [STEP_W-1:0]          r_k;
    logic                       r_done;
    logic signed [PHASE_BITS-1:0] r_angle;

    logic [CORDIC_W-1:0]        mag_x, mag_y;
    logic signed [CORDIC_W-1:0] xs, ys;
    logic [31:0]                z_rnd;

    assign mag_x = r_x[CORDIC_W-1] ? CORDIC_W'(-r_x) : CORDIC_W'(r_x);
    assign mag_y = r_y[CORDIC_W-1] ? CORDIC_W'(-r_y) : CORDIC_W'(r_y);
    assign xs    = r_x >>> r_k;
    assign ys    = r_y >>> r_k;
    assign z_rnd = r_z + (32'd1 << (31 - PHASE_BITS));

    assign o_done  = r_done;
    assign o_angle = r_angle;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= C_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                C_IDLE: begin
                    if (i_start) begin
                        r_x <= CORDIC_W'(i_x);
                        r_y <= CORDIC_W'(i_y);
                        r_z <= '0;
                        // a zero vector rounds straight to angle zero
                        r_state <= ((i_x == '0) && (i_y == '0)) ? C_RND : C_NORM;
                    end
                end
                C_NORM: begin
                    if ((mag_x < NORM_LIM) && (mag_y < NORM_LIM)) begin
                        r_x <= r_x <<< 1;
                        r_y <= r_y <<< 1;
                    end else begin
                        if (r_x[CORDIC_W-1]) begin
                            r_x <= -r_x;
                            r_y <= -r_y;
                            r_z <= 32'h8000_0000;
                        end
                        r_k     <= '0;
                        r_state <= C_ROT;
                    end
                end
                C_ROT: begin
                    if (!r_y[CORDIC_W-1]) begin
                        r_x <= r_x + ys;
                        r_y <= r_y - xs;
                        r_z <= r_z + cplf_angle(r_k);
                    end else begin
                        r_x <= r_x - ys;
                        r_y <= r_y + xs;
                        r_z <= r_z - cplf_angle(r_k);
                    end
                    r_k <= r_k + STEP_W'(1);
                    if (r_k == STEP_W'(CORDIC_STEPS - 1)) begin
                        r_state <= C_RND;
                    end
                end
                C_RND: begin
                    r_angle <= z_rnd[31 -: PHASE_BITS];
                    r_done  <= 1'b1;
                    r_state <= C_IDLE;
                end
                default: r_state <= C_IDLE;
            endcase
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/cplf_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cplf_back
// Unwraps phases, keeps the least-squares sums and, on the last transaction,
// solves the line fit with a serial multiplier and a restoring divider.
// ----------------------------------------------------------------------------
module cplf_back #(
    parameter int MAX_SAMPLES = cplf_pkg::MAX_SAMPLES_DEF,
    parameter int PHASE_BITS  = cplf_pkg::PHASE_BITS_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_q_valid,
    input  cplf_pkg::t_item                        i_q_item,
    input  wire logic [$clog2(MAX_SAMPLES)-1:0]    i_q_x,
    output logic                                   o_pop,
    output logic                                   o_valid,
    input  wire logic                              i_stall,
    output logic                                   o_fit_valid,
    output logic signed [31:0]                     o_slope,
    output logic signed [31:0]                     o_intercept,
    output logic signed [31:0]                     o_time_diff
);
    import cplf_pkg::*;

    localparam int XW   = $clog2(MAX_SAMPLES);
    localparam int CW   = $clog2(MAX_SAMPLES + 1);
    localparam int SXW  = 2 * XW;
    localparam int SXXW = 3 * XW;
    localparam int SYW  = 32 + XW;
    localparam int SXYW = 32 + 2 * XW;
    localparam int AW   = SXYW;
    localparam int PW   = 2 * AW;
    localparam int NDW  = PW + 18;
    localparam int MCW  = $clog2(AW);
    localparam int DCW  = $clog2(NDW);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_PHASE  = 4'd1;
    localparam logic [3:0] S_ACC    = 4'd2;
    localparam logic [3:0] S_FIT    = 4'd3;
    localparam logic [3:0] S_MLOAD  = 4'd4;
    localparam logic [3:0] S_MUL    = 4'd5;
    localparam logic [3:0] S_MFIX   = 4'd6;
    localparam logic [3:0] S_MSTORE = 4'd7;
    localparam logic [3:0] S_DLOAD  = 4'd8;
    localparam logic [3:0] S_DIV    = 4'd9;
    localparam logic [3:0] S_DFIX   = 4'd10;
    localparam logic [3:0] S_OUT    = 4'd11;

    // products of the fit, in the order they are formed
    localparam logic [2:0] K_N_SXX  = 3'd0;
    localparam logic [2:0] K_SX_SX  = 3'd1;
    localparam logic [2:0] K_N_SXY  = 3'd2;
    localparam logic [2:0] K_SX_SY  = 3'd3;
    localparam logic [2:0] K_SY_SXX = 3'd4;
    localparam logic [2:0] K_SX_SXY = 3'd5;

    logic [3:0]             r_state;
    logic [CW-1:0]          r_n;
    logic signed [31:0]     r_uph;
    logic [SXW-1:0]         r_sx;
    logic [SXXW-1:0]        r_sxx;
    logic signed [SYW-1:0]  r_sy;
    logic signed [SXYW-1:0] r_sxy;

    logic [2:0]             r_k;
    logic [PW-1:0]          r_ma, r_acc;
    logic [AW-1:0]          r_mb;
    logic                   r_mneg;
    logic [MCW-1:0]         r_mcnt;
    logic signed [PW-1:0]   r_prod, r_pa;
    logic [PW-1:0]          r_den;
    logic signed [PW:0]     r_nums, r_numi;

    logic                   r_dsel, r_dneg, r_big;
    logic [NDW-1:0]         r_dm;
    logic [PW-1:0]          r_rem;
    logic [31:0]            r_q;
    logic [DCW-1:0]         r_dcnt;
    logic signed [31:0]     r_slope, r_icpt;
    logic                   r_ok;

    logic                   r_ov, r_o_fit;
    logic signed [31:0]     r_o_slope, r_o_icpt, r_o_td;

    logic                   cord_start, cord_done;
    logic signed [PHASE_BITS-1:0] cord_angle;
    logic [PHASE_BITS-1:0]  d_pb;
    logic signed [31:0]     uph_new;
    logic [SXW-1:0]         xx;
    logic signed [XW+32:0]  xy;
    logic signed [AW-1:0]   op_a, op_b;
    logic [AW-1:0]          abs_a, abs_b;
    logic signed [PW:0]     diff;
    logic signed [PW:0]     num;
    logic [PW:0]            num_mag;
    logic [NDW-1:0]         num_sh;
    logic [PW:0]            rem2;
    logic                   ge;
    logic                   sat;
    logic                   out_load;

    cplf_cordic #(
        .PHASE_BITS (PHASE_BITS)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (cord_start),
        .i_x     (i_q_item.p_re),
        .i_y     (i_q_item.p_im),
        .o_done  (cord_done),
        .o_angle (cord_angle)
    );

    assign cord_start = (r_state == S_IDLE) && i_q_valid && i_q_item.fit;

    // unwrap against the previous phase; the first sample is taken as is
    assign d_pb    = cord_angle - r_uph[PHASE_BITS-1:0];
    assign uph_new = (r_n == '0) ? 32'(cord_angle) : r_uph + 32'($signed(d_pb));

    assign xx = i_q_x * i_q_x;
    assign xy = $signed({1'b0, i_q_x}) * r_uph;

    always_comb begin
        op_a = '0;
        op_b = '0;
        case (r_k)
            K_N_SXX:  begin op_a = AW'(r_n);  op_b = AW'(r_sxx); end
            K_SX_SX:  begin op_a = AW'(r_sx); op_b = AW'(r_sx);  end
            K_N_SXY:  begin op_a = AW'(r_n);  op_b = r_sxy;      end
            K_SX_SY:  begin op_a = AW'(r_sx); op_b = AW'(r_sy);  end
            K_SY_SXX: begin op_a = AW'(r_sy); op_b = AW'(r_sxx); end
            K_SX_SXY: begin op_a = AW'(r_sx); op_b = r_sxy;      end
            default:  begin op_a = '0;        op_b = '0;         end
        endcase
    end

    assign abs_a = op_a[AW-1] ? AW'(-op_a) : AW'(op_a);
    assign abs_b = op_b[AW-1] ? AW'(-op_b) : AW'(op_b);
    assign diff  = (PW+1)'(r_pa) - (PW+1)'(r_prod);

    assign num     = r_dsel ? r_numi : r_nums;
    assign num_mag = num[PW] ? (PW+1)'(-num) : (PW+1)'(num);
    assign num_sh  = (r_dsel ? (NDW'(num_mag) << 8) : (NDW'(num_mag) << 16))
                     + NDW'(r_den >> 1);

    assign rem2 = {r_rem, r_dm[NDW-1]};
    assign ge   = rem2 >= {1'b0, r_den};
    assign sat  = r_big || r_q[31];

    assign out_load = (r_state == S_OUT) && (!r_ov || !i_stall);

    assign o_pop = ((r_state == S_IDLE) && i_q_valid && !i_q_item.fit && !i_q_item.last)
                || ((r_state == S_ACC) && !i_q_item.last)
                || out_load;

    assign o_valid     = r_ov;
    assign o_fit_valid = r_o_fit;
    assign o_slope     = r_o_slope;
    assign o_intercept = r_o_icpt;
    assign o_time_diff = r_o_td;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ov    <= 1'b0;
            r_n     <= '0;
            r_uph   <= '0;
            r_sx    <= '0;
            r_sxx   <= '0;
            r_sy    <= '0;
            r_sxy   <= '0;
        end else begin
            if (out_load) begin
                r_ov <= 1'b1;
            end else if (!i_stall) begin
                r_ov <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_q_valid) begin
                        if (i_q_item.fit) begin
                            r_state <= S_PHASE;
                        end else if (i_q_item.last) begin
                            r_state <= S_FIT;
                        end
                    end
                end
                S_PHASE: begin
                    if (cord_done) begin
                        r_uph   <= uph_new;
                        r_state <= S_ACC;
                    end
                end
                S_ACC: begin
                    r_sx    <= r_sx + SXW'(i_q_x);
                    r_sxx   <= r_sxx + SXXW'(xx);
                    r_sy    <= r_sy + SYW'(r_uph);
                    r_sxy   <= r_sxy + SXYW'(xy);
                    r_n     <= r_n + CW'(1);
                    r_state <= i_q_item.last ? S_FIT : S_IDLE;
                end
                S_FIT: begin
                    r_k <= K_N_SXX;
                    if (i_q_item.cap_ok && (r_n >= CW'(2))) begin
                        r_state <= S_MLOAD;
                    end else begin
                        r_ok    <= 1'b0;
                        r_state <= S_OUT;
                    end
                end
                S_MLOAD: begin
                    r_ma    <= PW'(abs_a);
                    r_mb    <= abs_b;
                    r_mneg  <= op_a[AW-1] ^ op_b[AW-1];
                    r_acc   <= '0;
                    r_mcnt  <= '0;
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    if (r_mb[0]) begin
                        r_acc <= r_acc + r_ma;
                    end
                    r_ma   <= r_ma << 1;
                    r_mb   <= r_mb >> 1;
                    r_mcnt <= r_mcnt + MCW'(1);
                    if (r_mcnt == MCW'(AW - 1)) begin
                        r_state <= S_MFIX;
                    end
                end
                S_MFIX: begin
                    r_prod  <= r_mneg ? -$signed(r_acc) : $signed(r_acc);
                    r_state <= S_MSTORE;
                end
                S_MSTORE: begin
                    r_k     <= r_k + 3'd1;
                    r_state <= S_MLOAD;
                    case (r_k) inside
                        K_N_SXX, K_N_SXY, K_SY_SXX: r_pa <= r_prod;
                        K_SX_SX: begin
                            r_den <= diff[PW-1:0];
                            // a flat or degenerate index set gives no fit
                            if (diff[PW] || (diff == '0)) begin
                                r_ok    <= 1'b0;
                                r_state <= S_OUT;
                            end
                        end
                        K_SX_SY: r_nums <= diff;
                        default: begin
                            r_numi  <= diff;
                            r_dsel  <= 1'b0;
                            r_state <= S_DLOAD;
                        end
                    endcase
                end
                S_DLOAD: begin
                    r_dm    <= num_sh;
                    r_dneg  <= num[PW];
                    r_rem   <= '0;
                    r_q     <= '0;
                    r_big   <= 1'b0;
                    r_dcnt  <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_rem  <= ge ? PW'(rem2 - {1'b0, r_den}) : rem2[PW-1:0];
                    r_q    <= {r_q[30:0], ge};
                    r_big  <= r_big || r_q[31];
                    r_dm   <= r_dm << 1;
                    r_dcnt <= r_dcnt + DCW'(1);
                    if (r_dcnt == DCW'(NDW - 1)) begin
                        r_state <= S_DFIX;
                    end
                end
                S_DFIX: begin
                    if (!r_dsel) begin
                        r_slope <= r_dneg ? (sat ? 32'sh8000_0000 : -$signed(r_q))
                                          : (sat ? 32'sh7FFF_FFFF : $signed(r_q));
                        r_dsel  <= 1'b1;
                        r_state <= S_DLOAD;
                    end else begin
                        r_icpt  <= r_dneg ? (sat ? 32'sh8000_0000 : -$signed(r_q))
                                          : (sat ? 32'sh7FFF_FFFF : $signed(r_q));
                        r_ok    <= 1'b1;
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (out_load) begin
                        r_n     <= '0;
                        r_uph   <= '0;
                        r_sx    <= '0;
                        r_sxx   <= '0;
                        r_sy    <= '0;
                        r_sxy   <= '0;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_o_fit   <= r_ok;
            r_o_slope <= r_ok ? r_slope : 32'sd0;
            r_o_icpt  <= r_ok ? r_icpt : 32'sd0;
            r_o_td    <= $signed(i_q_item.tdiff);
        end
    end

    a_pop_has_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> i_q_valid) else $error("pop without a queued transaction");
    a_phase_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cord_done |-> (r_state == S_PHASE)) else $error("angle finished outside phase wait");
    a_result_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |-> i_q_item.last) else $error("result for a transaction not marked last");

endmodule
`default_nettype wire

// ===== rtl/core/cte_phase_line_fit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cte_phase_line_fit
// Least-squares line through the unwrapped phase of ref * conj(echo).
// ----------------------------------------------------------------------------
// The front accepts one sample pair per cycle into a two-entry queue, unless
// a full queue stalls it; the back end then works one transaction at a time.
// A pair with a nonzero echo waits on the iterative angle unit (one doubling
// per cycle until the vector reaches 2^40, then 28 vectoring steps); a
// skipped pair is popped without it. The transaction marked last adds the
// fit: up to six serial products of AW = 32 + 2*clog2(MAX_SAMPLES) bits,
// then two restoring divisions of a 2*AW + 18 bit numerator. One result
// leaves per capture through an output register, so the back end can start
// the next capture while it waits.
// ----------------------------------------------------------------------------
module cte_phase_line_fit #(
    parameter int MAX_SAMPLES = cplf_pkg::MAX_SAMPLES_DEF,
    parameter int PHASE_BITS  = cplf_pkg::PHASE_BITS_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_valid,
    output logic                              o_stall,
    input  wire logic signed [15:0]           i_ref_i,
    input  wire logic signed [15:0]           i_ref_q,
    input  wire logic signed [15:0]           i_echo_i,
    input  wire logic signed [15:0]           i_echo_q,
    input  wire logic                         i_last,
    input  wire logic                         i_captures_valid,
    input  wire logic [cplf_pkg::TIME_W-1:0]  i_ref_time,
    input  wire logic [cplf_pkg::TIME_W-1:0]  i_echo_time,
    output logic                              o_valid,
    input  wire logic                         i_stall,
    output logic                              o_fit_valid,
    output logic signed [31:0]                o_slope,
    output logic signed [31:0]                o_intercept,
    output logic signed [31:0]                o_time_diff
);
    import cplf_pkg::*;

    localparam int XW = $clog2(MAX_SAMPLES);
    localparam int QW = $bits(t_item) + XW;

    logic          push, full, q_valid, pop;
    t_item         f_item, q_item;
    logic [XW-1:0] f_x, q_x;
    logic [QW-1:0] q_data;

    cplf_front #(
        .MAX_SAMPLES (MAX_SAMPLES)
    ) u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_ref_i          (i_ref_i),
        .i_ref_q          (i_ref_q),
        .i_echo_i         (i_echo_i),
        .i_echo_q         (i_echo_q),
        .i_last           (i_last),
        .i_captures_valid (i_captures_valid),
        .i_ref_time       (i_ref_time),
        .i_echo_time      (i_echo_time),
        .o_push           (push),
        .o_item           (f_item),
        .o_x              (f_x),
        .i_full           (full)
    );

    cplf_queue #(
        .W (QW)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  ({f_x, f_item}),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_data  (q_data)
    );

    assign q_item = q_data[$bits(t_item)-1:0];
    assign q_x    = q_data[QW-1 -: XW];

    cplf_back #(
        .MAX_SAMPLES (MAX_SAMPLES),
        .PHASE_BITS  (PHASE_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_item    (q_item),
        .i_q_x       (q_x),
        .o_pop       (pop),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_fit_valid (o_fit_valid),
        .o_slope     (o_slope),
        .o_intercept (o_intercept),
        .o_time_diff (o_time_diff)
    );

endmodule
`default_nettype wire

// ===== tb/cte_phase_line_fit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cte_phase_line_fit_tb
// Self-checking bench for the I/Q phase line fit.
// ----------------------------------------------------------------------------
// Streams captures of reference/echo pairs with random gaps and output
// stalls. A local model forms the phase of ref * conj(echo) by CORDIC,
// unwraps it, fits the line on the last pair and queues the expected fit,
// which the monitor compares field by field with each transaction out.
// ----------------------------------------------------------------------------
module cte_phase_line_fit_tb;
    import cplf_pkg::*;

    localparam int MAX_N    = MAX_SAMPLES_DEF;
    localparam int PB       = PHASE_BITS_DEF;
    localparam int FIT_WAIT = 1500;
    localparam int IDLE_MAX = 20000;

    typedef struct {
        bit                 ok;
        logic signed [31:0] slope;
        logic signed [31:0] icpt;
        logic signed [31:0] tdiff;
    } t_fit;

    logic i_clk, i_rst_n;
    logic i_valid, o_stall, o_valid, i_stall;
    logic signed [15:0] i_ref_i, i_ref_q, i_echo_i, i_echo_q;
    logic i_last, i_captures_valid;
    logic [31:0] i_ref_time, i_echo_time;
    logic o_fit_valid;
    logic signed [31:0] o_slope, o_intercept, o_time_diff;

    cte_phase_line_fit u_top (
        .i_clk, .i_rst_n, .i_valid, .o_stall,
        .i_ref_i, .i_ref_q, .i_echo_i, .i_echo_q,
        .i_last, .i_captures_valid, .i_ref_time, .i_echo_time,
        .o_valid, .i_stall, .o_fit_valid, .o_slope, .o_intercept, .o_time_diff
    );

    // model state
    int unsigned    pair_idx, fit_cnt;
    int             phase_acc;
    longint         s_x, s_xx, s_y, s_xy;
    t_fit           fit_q[$];
    bit [31:0]      atan_lut[CORDIC_STEPS];

    int  errors, pairs_sent, fits_seen, fits_valid, burst_left, stall_hold;
    int  idle_cycles;
    bit  fill_hold;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        atan_lut = '{536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
                     10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
                     83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163,
                     81, 41, 20, 10, 5};
    end

    function automatic longint mag(longint v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic int pair_phase(longint x, longint y);
        bit [31:0] z, r;
        longint    xs, ys;
        if (x == 0 && y == 0)
            return 0;
        while (mag(x) < (64'sd1 <<< NORM_SHIFT) && mag(y) < (64'sd1 <<< NORM_SHIFT)) begin
            x = x * 2;
            y = y * 2;
        end
        z = 0;
        if (x < 0) begin
            x = -x;
            y = -y;
            z = 32'h8000_0000;
        end
        for (int k = 0; k < CORDIC_STEPS; k++) begin
            xs = x >>> k;
            ys = y >>> k;
            if (y >= 0) begin
                x = x + ys; y = y - xs; z = z + atan_lut[k];
            end else begin
                x = x - ys; y = y + xs; z = z - atan_lut[k];
            end
        end
        r = (z + (32'd1 << (31 - PB))) >> (32 - PB);
        return (r >= (1 << (PB - 1))) ? int'(r) - (1 << PB) : int'(r);
    endfunction

    // round half away from zero, saturate to 32 bit; den > 0
    function automatic logic signed [31:0] div_sat(logic signed [127:0] num, longint den,
                                                   int frac);
        logic [127:0] m, q;
        bit           neg;
        neg = num < 0;
        m   = neg ? -num : num;
        q   = ((m << frac) + (den / 2)) / den;
        if (neg)
            return (q >= 128'h8000_0000) ? 32'sh8000_0000 : -q[31:0];
        return (q > 128'h7FFF_FFFF) ? 32'sh7FFF_FFFF : q[31:0];
    endfunction

    task automatic fit_clear();
        pair_idx = 0; fit_cnt = 0; phase_acc = 0;
        s_x = 0; s_xx = 0; s_y = 0; s_xy = 0;
    endtask

    task automatic model_pair(logic signed [15:0] ri, rq, ei, eq, bit lst, bit cv,
                              bit [31:0] rt, et);
        longint             x, d, den;
        int                 ph;
        logic signed [127:0] ns, ni;
        t_fit               f;
        if (pair_idx < MAX_N) begin
            if (ei != 0 || eq != 0) begin
                ph = pair_phase(longint'(ri) * ei + longint'(rq) * eq,
                                longint'(rq) * ei - longint'(ri) * eq);
                x  = pair_idx;
                if (fit_cnt == 0) begin
                    phase_acc = ph;
                end else begin
                    d = (ph - phase_acc) & ((1 << PB) - 1);
                    if (d >= (1 << (PB - 1)))
                        d = d - (1 << PB);
                    phase_acc = phase_acc + int'(d);
                end
                s_x  += x;
                s_xx += x * x;
                s_y  += phase_acc;
                s_xy += x * phase_acc;
                fit_cnt++;
            end
            pair_idx++;
        end
        if (!lst)
            return;
        f.ok = 0; f.slope = 0; f.icpt = 0;
        f.tdiff = et - rt;
        if (cv && fit_cnt >= 2) begin
            den = longint'(fit_cnt) * s_xx - s_x * s_x;
            if (den > 0) begin
                ns = 128'(signed'(fit_cnt)) * s_xy - 128'(s_x) * s_y;
                ni = 128'(s_y) * s_xx - 128'(s_x) * s_xy;
                f.slope = div_sat(ns, den, 16);
                f.icpt  = div_sat(ni, den, 8);
                f.ok    = 1;
            end
        end
        fit_q.push_back(f);
        fit_clear();
    endtask

    // drive one pair and hold it until accepted
    task automatic send_pair(logic signed [15:0] ri, rq, ei, eq, bit lst, bit cv = 1);
        bit [31:0] rt, et;
        rt = $urandom;
        et = $urandom;
        if (burst_left == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        i_valid <= 1'b1;
        i_ref_i <= ri; i_ref_q <= rq; i_echo_i <= ei; i_echo_q <= eq;
        i_last <= lst; i_captures_valid <= cv;
        i_ref_time <= rt; i_echo_time <= et;
        do @(posedge i_clk); while (o_stall);
        model_pair(ri, rq, ei, eq, lst, cv, rt, et);
        pairs_sent++;
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        wait (fit_q.size() == 0);
        repeat (FIT_WAIT) @(posedge i_clk);
    endtask

    function automatic logic signed [15:0] rnd16();
        case ($urandom_range(0, 7))
            0: return 16'sh8000;
            1: return 16'sh7FFF;
            2: return 16'($urandom_range(0, 15)) - 16'sd8;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic test_extremes();
        send_pair(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 0);
        send_pair(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 0);
        send_pair(16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'sh8000, 0);
        send_pair(16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh7FFF, 0);
        send_pair(16'sh0000, 16'sh0000, 16'sh0001, 16'sh0000, 0);  // zero reference
        send_pair(16'sh0001, 16'sh0000, 16'sh0000, 16'sh0000, 0);  // zero echo skipped
        send_pair(16'shFFFF, 16'sh0001, 16'sh0001, 16'shFFFF, 1);
    endtask

    task automatic test_invalid_fits();
        send_pair(16'sd100, 16'sd5, 16'sd7, 16'sd9, 0);
        send_pair(16'sd3, 16'sd100, 16'sd7, 16'sd9, 1, 0);      // captures flagged bad
        send_pair(16'sd100, 16'sd5, 16'sd7, 16'sd9, 0);
        send_pair(16'sd100, 16'sd5, 16'sd0, 16'sd0, 1);        // one usable sample
        send_pair(16'sd9, 16'sd9, 16'sd0, 16'sd0, 1);          // no usable sample
        send_pair(16'sd9, 16'sd9, 16'sd1, 16'sd1, 1);          // single pair capture
    endtask

    // near half-turn steps drive the slope and intercept to saturation
    task automatic test_saturation();
        for (int k = 0; k < 12; k++)
            send_pair(16'sd30000, 16'sd0, (k % 2) ? -16'sd30000 : 16'sd30000,
                      (k % 2) ? 16'sd1 : 16'sd0, k == 11);
        for (int k = 0; k < 8; k++)
            send_pair(16'sd30000, 16'sd0, (k % 2) ? -16'sd30000 : 16'sd30000,
                      (k % 2) ? -16'sd1 : 16'sd0, k == 7);
    endtask

    task automatic test_long_capture();
        for (int k = 0; k < MAX_N + 40; k++)
            send_pair(rnd16(), rnd16(), rnd16(), rnd16(), k == MAX_N + 39);
    endtask

    task automatic send_capture(int len);
        logic signed [15:0] ri, rq, ei, eq;
        bit                 smooth;
        smooth = $urandom_range(0, 3) != 0;
        ri = rnd16(); rq = rnd16(); ei = rnd16(); eq = rnd16();
        for (int k = 0; k < len; k++) begin
            if (smooth) begin
                // slow drift of the echo keeps the phase line well formed
                ei = ei + 16'($urandom_range(0, 1023)) - 16'sd512;
                eq = eq + 16'($urandom_range(0, 1023)) - 16'sd512;
            end else begin
                ri = rnd16(); rq = rnd16(); ei = rnd16(); eq = rnd16();
            end
            if ($urandom_range(0, 9) == 0)
                send_pair(ri, rq, 0, 0, k == len - 1, $urandom_range(0, 15) != 0);
            else
                send_pair(ri, rq, ei, eq, k == len - 1, $urandom_range(0, 15) != 0);
        end
    endtask

    task automatic test_random();
        int len;
        while (pairs_sent < 2000) begin
            case ($urandom_range(0, 39))
                0:       len = $urandom_range(MAX_N - 2, MAX_N + 20);
                1, 2:    len = 1;
                default: len = $urandom_range(2, 24);
            endcase
            send_capture(len);
        end
    endtask

    // hold the output long enough that two fits wait and the queue fills
    task automatic test_backpressure();
        fill_hold = 1;
        send_capture(4);
        send_capture(3);
        send_capture(6);
        drain();
        send_capture(6);
    endtask

    // result checker and watchdog
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                fits_seen++;
                if (fit_q.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("ERROR: unexpected fit transaction at %0t", $realtime);
                end else begin
                    if (fit_q[0].ok !== o_fit_valid || fit_q[0].slope !== o_slope ||
                        fit_q[0].icpt !== o_intercept || fit_q[0].tdiff !== o_time_diff) begin
                        errors++;
                        if (errors <= 10)
                            $display({"ERROR: fit exp ok=%0b s=%0d i=%0d t=%0d",
                                      " got ok=%0b s=%0d i=%0d t=%0d"},
                                     fit_q[0].ok, fit_q[0].slope, fit_q[0].icpt, fit_q[0].tdiff,
                                     o_fit_valid, o_slope, o_intercept, o_time_diff);
                    end
                    fits_valid += fit_q[0].ok;
                    void'(fit_q.pop_front());
                end
            end
            if ((o_valid && !i_stall) || (i_valid && !o_stall))
                idle_cycles = 0;
            else if (++idle_cycles >= IDLE_MAX) begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    // output stall pattern, with one long hold on request
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (fill_hold && stall_hold == 0) begin
                stall_hold = 3000;
                fill_hold  = 0;
            end
            if (stall_hold > 0) begin
                stall_hold--;
                i_stall <= 1'b1;
            end else begin
                // stall phase shifts with a random duty
                i_stall <= ($urandom_range(0, 99) < (((pairs_sent / 300) % 2) ? 45 : 0));
            end
        end
    end

    initial begin
        errors = 0; pairs_sent = 0; fits_seen = 0; fits_valid = 0;
        burst_left = 0; stall_hold = 0; idle_cycles = 0; fill_hold = 0;
        fit_clear();
        i_rst_n <= 1'b0; i_valid <= 1'b0; i_stall <= 1'b0;
        i_ref_i <= '0; i_ref_q <= '0; i_echo_i <= '0; i_echo_q <= '0;
        i_last <= 1'b0; i_captures_valid <= 1'b0;
        i_ref_time <= '0; i_echo_time <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_extremes();
        test_invalid_fits();
        test_saturation();
        test_long_capture();
        test_backpressure();
        test_random();
        drain();
        $display("Covered %0d sample pairs and %0d fits (%0d valid), with output stalls",
                 pairs_sent, fits_seen, fits_valid);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/cplf_pkg.sv
rtl/core/cplf_front.sv
rtl/core/cplf_queue.sv
rtl/core/cplf_cordic.sv
rtl/core/cplf_back.sv
rtl/core/cte_phase_line_fit.sv
tb/cte_phase_line_fit_tb.sv
